// File: hdl/gnc_pkg.sv
// Shared types, constants and helpers for the 3x3 grid neighbor counter.
// Used by gnc_front, gnc_queue, gnc_back and grid_neighbor_count_3x3.
package gnc_pkg;

    // Size defaults for the line buffer and the row counter
    localparam int DEFAULT_MAX_WIDTH  = 1024;
    localparam int DEFAULT_MAX_HEIGHT = 1024;

    // Grid size after reset, in cells
    localparam int DIM_RESET = 6;

    // Configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    // Result fields
    localparam int COORD_W = 10;
    localparam int COUNT_W = 4;

    // 3x3 window, newest column in the low three bits (top, mid, bottom)
    localparam int WIN_W = 9;
    localparam logic [WIN_W-1:0] WIN_ALL  = 9'h1FF;
    localparam logic [WIN_W-1:0] WIN_COLS = 9'h03F;  // drop the column right of the grid
    localparam logic [WIN_W-1:0] WIN_ROWS = 9'h1B6;  // drop the row below the grid

    // Candidate results of one item, in output order
    localparam int RES_N = 4;
    localparam logic [1:0] RES_UP_LEFT  = 2'd0;
    localparam logic [1:0] RES_UP_SELF  = 2'd1;
    localparam logic [1:0] RES_CUR_LEFT = 2'd2;
    localparam logic [1:0] RES_CUR_SELF = 2'd3;

    // Job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // One classified item: window, position and which results it completes
    typedef struct packed {
        logic [WIN_W-1:0]   win;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [RES_N-1:0]   res_mask;
    } job_t;

    // Count set bits of a window
    function automatic logic [COUNT_W-1:0] popcount9(input logic [WIN_W-1:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < WIN_W; i++)
        begin
            n = n + {{(COUNT_W-1){1'b0}}, v[i]};
        end
        return n;
    endfunction

endpackage

// File: hdl/grid_neighbor_count_3x3.sv
// 3x3 neighbor count over a streamed occupancy grid.
//
// Input stream s_*: one cell per item in raster order, s_tdata[0] = occupied.
// Output stream m_*: one count per grid cell, tagged with its row and column.
// A count leaves as soon as its window is complete; one cell can complete up
// to four windows on the last row and column, and m_tlast marks the final one
// of these. m_tuser marks the count of the grid's last cell.
// Config channel cfg_*: index 0 grid width, index 1 grid height (1..MAX, 0 is
// taken as 1, larger values clamp). A write restarts the grid at row 0.
//
// Throughput: one cell per cycle in and one result per cycle out, unless stalled;
// a cell that completes several windows holds the result sequencer until all of
// them are out. The first result of a cell takes these steps: line buffer read
// and stage register load on the edge that takes it, the job enters the queue on
// the next edge, then the output register loads from the queue head. Reset:
// position and window clear, size returns to 6 x 6; the line buffer is not
// cleared. A stalled m_tready holds the output register; the four-entry queue
// absorbs the front end until queued plus in-flight jobs fill it; s_tready drops.
// Depends on gnc_pkg, gnc_front, gnc_queue, gnc_back.
module grid_neighbor_count_3x3
    import gnc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [0] occupied, [7:1] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,    // [3:0] neighbor_count, [13:4] out_row,
                                              // [23:14] out_col
    output logic                  m_tlast,    // last_of_run
    output logic                  m_tuser,    // frame_done
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic            job_valid;
    job_t            job;
    job_t            head;
    logic            q_empty;
    logic [Q_CW-1:0] q_count;
    logic            pop;

    // Position tracking, line buffer and window
    gnc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_occupied (s_tdata[0]),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_count     (q_count),
        .job_valid   (job_valid),
        .job         (job)
    );

    // Decouple classification from result sequencing
    gnc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_valid),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .count    (q_count)
    );

    // Emit the counts of each job
    gnc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/gnc_front.sv
// Front end: accepts cells, tracks the raster position, keeps two buffered rows
// and the 3x3 window, and pushes one job per item that completes any window.
// Depends on gnc_pkg.
module gnc_front
    import gnc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_occupied,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [Q_CW-1:0]       q_count,
    output logic                  job_valid,
    output job_t                  job
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RST_W_M1 = ((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET) - 1;
    localparam int RST_H_M1 = ((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET) - 1;

    // Grid size, stored as size minus one after clamping
    logic [CW-1:0] w_m1_reg, w_m1_next;
    logic [RW-1:0] h_m1_reg, h_m1_next;

    // Position of the next cell
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // Second stage: the cell whose line buffer read is in flight
    logic          s1_valid_reg;
    logic          s1_bot_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_last_col_reg;
    logic          s1_last_row_reg;

    // Line buffer: bit 1 row above, bit 0 row two above
    logic [1:0]    line_mem [MAX_WIDTH];
    logic [1:0]    rd_reg;
    logic          fwd_reg;
    logic [1:0]    fwd_data_reg;

    logic [WIN_W-1:0] window_reg, window_next;

    logic          accept;
    logic          cfg_hit;
    logic [31:0]   cfg_val;
    logic [31:0]   w_clamp;
    logic [31:0]   h_clamp;
    logic          last_col;
    logic          last_row;
    logic          above;
    logic          two_above;
    logic          mid;
    logic          top;
    logic [2:0]    column;
    logic          up;
    logic          left;
    logic [31:0]   row_wide;
    logic [31:0]   col_wide;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid
                       && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

    // Leave room in the queue for every item still in flight
    assign in_ready = ({1'b0, q_count} + {{Q_CW{1'b0}}, s1_valid_reg}) < (Q_CW+1)'(Q_DEPTH);
    assign accept   = in_valid && in_ready;

    assign last_col = (col_reg == w_m1_reg);
    assign last_row = (row_reg == h_m1_reg);

    // Clamp a written size to 1..MAX and keep it as size minus one
    always_comb
    begin
        cfg_val = 32'(cfg_data);
        if (cfg_val == 32'd0)
            w_clamp = 32'd0;
        else if (cfg_val > 32'(MAX_WIDTH))
            w_clamp = 32'(MAX_WIDTH) - 32'd1;
        else
            w_clamp = cfg_val - 32'd1;
        if (cfg_val == 32'd0)
            h_clamp = 32'd0;
        else if (cfg_val > 32'(MAX_HEIGHT))
            h_clamp = 32'(MAX_HEIGHT) - 32'd1;
        else
            h_clamp = cfg_val - 32'd1;

        w_m1_next = w_m1_reg;
        h_m1_next = h_m1_reg;
        if (cfg_valid && cfg_index == REG_GRID_WIDTH)
            w_m1_next = CW'(w_clamp);
        if (cfg_valid && cfg_index == REG_GRID_HEIGHT)
            h_m1_next = RW'(h_clamp);
    end

    // Advance the raster position; a size write restarts the grid
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    // Build the new window column; rows above row 0 count as empty
    always_comb
    begin
        above     = fwd_reg ? fwd_data_reg[1] : rd_reg[1];
        two_above = fwd_reg ? fwd_data_reg[0] : rd_reg[0];
        mid       = (s1_row_reg != '0) && above;
        top       = (s1_row_reg > RW'(1)) && two_above;
        column    = {s1_bot_reg, mid, top};
        if (s1_col_reg == '0)
            window_next = {6'b0, column};
        else
            window_next = {window_reg[5:0], column};
    end

    // Classify which windows this cell completes
    always_comb
    begin
        up       = (s1_row_reg != '0);
        left     = (s1_col_reg != '0);
        row_wide = 32'(s1_row_reg);
        col_wide = 32'(s1_col_reg);
        job.win  = window_next;
        job.row  = row_wide[COORD_W-1:0];
        job.col  = col_wide[COORD_W-1:0];
        job.res_mask[RES_UP_LEFT]  = up && left;
        job.res_mask[RES_UP_SELF]  = up && s1_last_col_reg;
        job.res_mask[RES_CUR_LEFT] = s1_last_row_reg && left;
        job.res_mask[RES_CUR_SELF] = s1_last_row_reg && s1_last_col_reg;
        job_valid = s1_valid_reg && (job.res_mask != '0);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg     <= CW'(RST_W_M1);
            h_m1_reg     <= RW'(RST_H_M1);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            w_m1_reg     <= w_m1_next;
            h_m1_reg     <= h_m1_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            // Same column written this edge as read: take the fresh bits
            fwd_reg      <= accept && s1_valid_reg && (s1_col_reg == col_reg);
            if (cfg_hit)
                window_reg <= '0;
            else if (s1_valid_reg)
                window_reg <= window_next;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bot_reg      <= in_occupied;
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
        fwd_data_reg <= {s1_bot_reg, mid};
    end

    // Line buffer: read at accept, write back in the cycle after. Every column is
    // written in row 0 before any later row reads it, so the buffer needs no clearing.
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            line_mem[s1_col_reg] <= {s1_bot_reg, mid};
        if (accept)
            rd_reg <= line_mem[col_reg];
    end

endmodule

// File: hdl/gnc_queue.sv
// Short job queue between the front end and the result sequencer.
// Depends on gnc_pkg.
module gnc_queue
    import gnc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  job_t            push_job,
    input  logic            pop,
    output job_t            head,
    output logic            empty,
    output logic [Q_CW-1:0] count
);

    job_t            slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + Q_CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - Q_CW'(1);
        end
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// File: hdl/gnc_back.sv
// Back end: walks the completed windows of each job and drives the output
// stream from a registered stage, one result per cycle while the output is not stalled.
// Depends on gnc_pkg.
module gnc_back
    import gnc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  logic        q_empty,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] neighbor_count, [13:4] out_row, [23:14] out_col
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // frame_done
);

    job_t               job_reg;
    logic [RES_N-1:0]   mask_reg;

    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [COORD_W-1:0] m_row_reg;
    logic [COORD_W-1:0] m_col_reg;
    logic               m_last_reg;
    logic               m_done_reg;

    logic               busy;
    logic               out_free;
    logic               take;
    job_t               cur;
    logic [RES_N-1:0]   cur_mask;
    logic [RES_N-1:0]   rest_mask;
    logic [1:0]         sel;
    logic [COUNT_W-1:0] count_val;
    logic [COORD_W-1:0] row_val;
    logic [COORD_W-1:0] col_val;

    assign busy     = (mask_reg != '0);
    assign out_free = !m_valid_reg || m_tready;
    assign take     = out_free && (busy || !q_empty);
    assign pop      = out_free && !busy && !q_empty;
    assign cur      = busy ? job_reg : head;
    assign cur_mask = busy ? mask_reg : head.res_mask;
    assign rest_mask = cur_mask & (cur_mask - RES_N'(1));

    // Pick the lowest pending result
    always_comb
    begin
        if (cur_mask[RES_UP_LEFT])
            sel = RES_UP_LEFT;
        else if (cur_mask[RES_UP_SELF])
            sel = RES_UP_SELF;
        else if (cur_mask[RES_CUR_LEFT])
            sel = RES_CUR_LEFT;
        else
            sel = RES_CUR_SELF;
    end

    // Mask the window and set the cell position for that result
    always_comb
    begin
        case (sel)
            RES_UP_LEFT:
            begin
                count_val = popcount9(cur.win & WIN_ALL);
                row_val   = cur.row - COORD_W'(1);
                col_val   = cur.col - COORD_W'(1);
            end
            RES_UP_SELF:
            begin
                count_val = popcount9(cur.win & WIN_COLS);
                row_val   = cur.row - COORD_W'(1);
                col_val   = cur.col;
            end
            RES_CUR_LEFT:
            begin
                count_val = popcount9(cur.win & WIN_ROWS);
                row_val   = cur.row;
                col_val   = cur.col - COORD_W'(1);
            end
            default:
            begin
                count_val = popcount9(cur.win & WIN_ROWS & WIN_COLS);
                row_val   = cur.row;
                col_val   = cur.col;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
                mask_reg <= rest_mask;
            if (out_free)
                m_valid_reg <= take;
        end
    end

    // Output and job payload
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head;
        if (take)
        begin
            m_count_reg <= count_val;
            m_row_reg   <= row_val;
            m_col_reg   <= col_val;
            m_last_reg  <= (rest_mask == '0);
            m_done_reg  <= (sel == RES_CUR_SELF);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_col_reg, m_row_reg, m_count_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_done_reg;

endmodule

// File: sim/grid_neighbor_count_3x3_tb.sv
// Self-checking testbench for grid_neighbor_count_3x3: streams occupancy grids
// of many sizes, predicts every 3x3 count and checks each result item in order.
// Depends on gnc_pkg and the grid_neighbor_count_3x3 RTL.
`timescale 1ns / 1ps

module grid_neighbor_count_3x3_tb;
    import gnc_pkg::*;

    localparam int MAX_DIM        = DEFAULT_MAX_WIDTH;
    localparam int DRAIN_CYCLES   = 16;
    localparam int QUIET_LIMIT    = 4000;
    localparam int RANDOM_TARGET  = 300;
    localparam int MAX_PRINTED    = 40;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    // One expected count, fields as they appear on the output stream
    typedef struct packed {
        logic [3:0] count;
        logic [9:0] row;
        logic [9:0] col;
        logic       last;
        logic       fdone;
    } cell_count_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Stimulus and expected counts
    logic        pending_cells[$];
    cell_count_t expected_counts[$];

    // Predictor state: line buffers, window, position and grid size
    logic              line_two_up [0:MAX_DIM-1];
    logic              line_one_up [0:MAX_DIM-1];
    logic [WIN_W-1:0]  win_bits   = '0;
    int unsigned       next_row   = 0;
    int unsigned       next_col   = 0;
    logic [10:0]       grid_w     = 11'(DIM_RESET);
    logic [10:0]       grid_h     = 11'(DIM_RESET);

    // Idle controls and run statistics
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cells_sent     = 0;
    int unsigned counts_checked = 0;
    int unsigned frames_seen    = 0;
    int unsigned reg_writes     = 0;
    int unsigned phase_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;

    grid_neighbor_count_3x3 uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Zero and oversized sizes fold into 1..MAX_DIM
    function automatic int unsigned eff_dim(input logic [10:0] v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic cell_count_t window_result(input logic [WIN_W-1:0] mask,
            input int unsigned row, input int unsigned col, input logic fdone);
        cell_count_t res;
        res.count = 4'($countones(win_bits & mask));
        res.row   = 10'(row);
        res.col   = 10'(col);
        res.last  = 1'b0;
        res.fdone = fdone;
        return res;
    endfunction

    // Shift one cell into the window and queue every count it completes
    function automatic void take_cell(input logic occ);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic        top;
        logic        mid;
        cell_count_t run[$];
        w = eff_dim(grid_w);
        h = eff_dim(grid_h);
        r = next_row;
        c = next_col;
        if (c >= w || r >= h)
        begin
            r = 0;
            c = 0;
        end
        // rows above the grid start count as empty
        top = (r >= 2) ? line_two_up[c] : 1'b0;
        mid = (r >= 1) ? line_one_up[c] : 1'b0;
        line_two_up[c] = mid;
        line_one_up[c] = occ;
        win_bits = (c == 0) ? {6'b0, occ, mid, top} : {win_bits[5:0], occ, mid, top};
        if (r >= 1 && c >= 1)
        begin
            run.push_back(window_result(WIN_ALL, r - 1, c - 1, 1'b0));
        end
        if (r >= 1 && c == w - 1)
        begin
            run.push_back(window_result(WIN_COLS, r - 1, c, 1'b0));
        end
        if (r == h - 1 && c >= 1)
        begin
            run.push_back(window_result(WIN_ROWS, r, c - 1, 1'b0));
        end
        if (r == h - 1 && c == w - 1)
        begin
            run.push_back(window_result(WIN_ROWS & WIN_COLS, r, c, 1'b1));
        end
        if (run.size() > 0)
        begin
            run[run.size() - 1].last = 1'b1;
        end
        foreach (run[i])
        begin
            expected_counts.push_back(run[i]);
        end
        // advance the raster position, wrapping at the end of the grid
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        next_row = r;
        next_col = c;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Driver: offer queued cells, predict on every accepted item
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                take_cell(s_tdata[0]);
                cells_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cells.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, pending_cells.pop_front()};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result with the oldest expectation
    always @(posedge clk)
    begin : check_out
        cell_count_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                counts_checked++;
                if (m_tuser)
                begin
                    frames_seen++;
                end
                if (expected_counts.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected count %0d at (%0d,%0d)",
                        m_tdata[3:0], m_tdata[13:4], m_tdata[23:14]));
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (m_tdata[3:0] != want.count)
                        flag_mismatch($sformatf("count at (%0d,%0d): got %0d want %0d",
                            want.row, want.col, m_tdata[3:0], want.count));
                    if (m_tdata[13:4] != want.row)
                        flag_mismatch($sformatf("row: got %0d want %0d",
                            m_tdata[13:4], want.row));
                    if (m_tdata[23:14] != want.col)
                        flag_mismatch($sformatf("col: got %0d want %0d",
                            m_tdata[23:14], want.col));
                    if (m_tlast != want.last)
                        flag_mismatch($sformatf("tlast at (%0d,%0d): got %0b want %0b",
                            want.row, want.col, m_tlast, want.last));
                    if (m_tuser != want.fdone)
                        flag_mismatch($sformatf("tuser at (%0d,%0d): got %0b want %0b",
                            want.row, want.col, m_tuser, want.fdone));
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Track register writes: a known index restarts the grid
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            reg_writes++;
            if (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT)
            begin
                if (cfg_index == REG_GRID_WIDTH)
                    grid_w = cfg_data;
                else
                    grid_h = cfg_data;
                next_row = 0;
                next_col = 0;
                win_bits = '0;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d counts outstanding",
                    quiet_cycles, expected_counts.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Hold until every cell is taken and every count has come back
    task automatic wait_idle(input int drain);
        while (pending_cells.size() != 0 || s_tvalid || expected_counts.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (drain) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [10:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drain, pick the idle pattern for this phase, then resize the grid
    task automatic set_grid(input int unsigned w, input int unsigned h);
        wait_idle(DRAIN_CYCLES);
        case (phase_count % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
        phase_count++;
        write_reg(REG_GRID_WIDTH, 11'(w));
        write_reg(REG_GRID_HEIGHT, 11'(h));
    endtask

    task automatic queue_cells(input int unsigned n, input int unsigned pct);
        repeat (n) pending_cells.push_back($urandom_range(0, 99) < pct);
    endtask

    task automatic queue_ones(input int unsigned n);
        repeat (n) pending_cells.push_back(1'b1);
    endtask

    initial
    begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned area;
        int unsigned n;
        int unsigned pct;
        int unsigned random_cells;
        for (int i = 0; i < MAX_DIM; i++)
        begin
            line_two_up[i] = 1'b0;
            line_one_up[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset size 6x6, one random frame, no idling
        queue_cells(36, 50);
        random_cells = 36;
        phase_count  = 1;

        // 3x3 all occupied; a write to a spare index mid-frame changes nothing
        set_grid(3, 3);
        queue_ones(4);
        wait_idle(DRAIN_CYCLES);
        write_reg(REG_SPARE, 11'h7FF);
        queue_ones(5);

        // Zero sizes act as a 1x1 grid
        set_grid(0, 0);
        pending_cells.push_back(1'b1);
        pending_cells.push_back(1'b0);

        // Partial grid, abandoned by the next size write
        set_grid(4, 4);
        queue_ones(6);

        // Single row of two
        set_grid(2, 1);
        queue_ones(2);

        // Oversized width and height saturate; start of each clamped grid
        set_grid(2047, 2);
        queue_cells(20, 50);
        set_grid(1, 2047);
        queue_cells(20, 50);

        // Random sizes, mostly whole frames with random content
        while (random_cells < RANDOM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: begin w = $urandom_range(13, 40); h = $urandom_range(1, 3); end
                1: begin w = $urandom_range(1, 3);   h = $urandom_range(13, 40); end
                2: begin w = 0;                      h = $urandom_range(0, 5); end
                3: begin w = $urandom_range(1, 5);   h = 0; end
                default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
            endcase
            case ($urandom_range(0, 3))
                0: pct = 10;
                1: pct = 90;
                default: pct = 50;
            endcase
            area = eff_dim(11'(w)) * eff_dim(11'(h));
            n = area * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
            begin
                n = n + $urandom_range(0, area);
            end
            set_grid(w, h);
            // hold the sender until the block has drained, at least once
            if (random_cells == 36 || $urandom_range(0, 3) == 0)
            begin
                queue_cells(n / 2, pct);
                wait_idle(0);
                queue_cells(n - n / 2, pct);
            end
            else
            begin
                queue_cells(n, pct);
            end
            random_cells += n;
        end

        wait_idle(DRAIN_CYCLES);
        $display("Run covered %0d cells over %0d grid sizes with %0d register writes.",
            cells_sent, phase_count, reg_writes);
        $display("Checked %0d counts across %0d completed grids, %0d mismatches.",
            counts_checked, frames_seen, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
